[hdl/swfn_pkg.sv]
// ----------------------------------------------------------------------------
// swfn_pkg: shared types for the sliding window first negative block
// Holds the FIFO entry layout and the structs passed between the top level
// and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swfn_pkg;

  localparam int OUT_W = 32;
  localparam int POS_W = 16;
  localparam int CFG_W = 7;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [POS_W-1:0] pos;
  } swfn_entry_t;

  typedef struct packed {
    logic             go;
    logic             sos;
    logic             neg;
    logic [OUT_W-1:0] value;
  } swfn_step_t;

  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] value;
  } swfn_result_t;

endpackage

`default_nettype wire

[hdl/sliding_window_first_negative_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_first_negative_core: oldest negative sample in a window
// Input samples arrive on a valid/ready channel with a start of sequence
// flag. Once window_size samples of the current sequence have been taken,
// each input transaction produces one output transaction carrying the
// oldest negative sample of the last window_size samples, or zero.
// Shorter sequences produce no output.
// The user must write the window size via cfg_write_en and cfg_write_data
// only while the block is idle; this is not enforced. Zero acts as one and
// values above MAX_WINDOW saturate. An accepted transaction waits in the
// input register until the output register can take its result. The block
// takes one transaction per cycle while the receiver does not stall, set by
// the single pass through the registered FIFO front and the RAM prefetch
// of the third entry. When the receiver stalls, the output register holds
// its result and in_ready drops once the input register is full.
// Reset empties the FIFO, clears the counters and sets the window size to 1.
// The FIFO RAM needs no clearing; entries are used only after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_first_negative_core
  import swfn_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [OUT_W-1:0] in_sample,
  input  wire logic                    in_start_of_sequence,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_first_negative,
  input  wire logic                    cfg_write_en,
  input  wire logic [CFG_W-1:0]        cfg_write_data
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic                    s1_valid_r;
  logic signed [OUT_W-1:0] s1_sample_r;
  logic                    s1_sos_r;
  logic                    s1_go;
  logic [CFG_W-1:0]        window_size_r;
  logic [CNT_W-1:0]        window;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  logic signed [SAMPLE_BITS-1:0] smp;
  swfn_step_t                    step;
  swfn_result_t                  result;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    if (window_size_r == '0) begin
      window = CNT_W'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      window = CNT_W'(MAX_WINDOW);
    end else begin
      window = CNT_W'(window_size_r);
    end
  end

  always_comb begin
    smp        = SAMPLE_BITS'(s1_sample_r);
    step.go    = s1_go;
    step.sos   = s1_sos_r;
    step.neg   = smp[SAMPLE_BITS-1];
    step.value = OUT_W'(smp);
  end

  swfn_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .window (window),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      window_size_r <= CFG_W'(1);
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r <= result.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        window_size_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_sos_r    <= in_start_of_sequence;
    end
    if (s1_go && result.emit) begin
      out_data_r <= result.value;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_negative = out_data_r;

endmodule

`default_nettype wire

[hdl/swfn_ram.sv]
// ----------------------------------------------------------------------------
// swfn_ram: generic simple dual port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module swfn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/swfn_window.sv]
// ----------------------------------------------------------------------------
// swfn_window: negative sample FIFO and window bookkeeping
// Keeps the first two FIFO entries in registers and prefetches the third
// from the RAM so that one expire or drop per transaction needs no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module swfn_window
  import swfn_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swfn_step_t         step,
  input  wire logic [CNT_W-1:0]   window,
  output swfn_result_t            result
);

  function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(MAX_WINDOW - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, seen_r, seen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  swfn_entry_t      f0_r, f0_nxt, f1_r, f1_nxt, byp_r, byp_nxt;
  logic             use_byp_r, use_byp_nxt;

  logic [IDX_W-1:0] head_e, tail_e, rd_addr;
  logic [CNT_W-1:0] count_e, seen_e, cpop;
  logic [POS_W-1:0] pos_e, age;
  logic             expire, full_drop, pop;
  swfn_entry_t      push_e, third, sh0, sh1;
  logic [$bits(swfn_entry_t)-1:0] rd_data;

  always_comb begin
    head_e  = step.sos ? '0 : head_r;
    tail_e  = step.sos ? '0 : tail_r;
    count_e = step.sos ? '0 : count_r;
    seen_e  = step.sos ? '0 : seen_r;
    pos_e   = step.sos ? '0 : pos_r;

    age       = pos_e - f0_r.pos;
    expire    = (count_e != '0) && (age >= POS_W'(window));
    full_drop = step.neg && !expire && (count_e == CNT_W'(MAX_WINDOW));
    pop       = expire || full_drop;
    cpop      = count_e - CNT_W'(pop);

    push_e.value = step.value;
    push_e.pos   = pos_e;

    third = use_byp_r ? byp_r : swfn_entry_t'(rd_data);
    sh0   = pop ? f1_r : f0_r;
    sh1   = pop ? third : f1_r;

    f0_nxt      = (cpop == CNT_W'(0)) ? push_e : sh0;
    f1_nxt      = (cpop == CNT_W'(1)) ? push_e : sh1;
    head_nxt    = pop ? inc(head_e) : head_e;
    rd_addr     = inc(inc(head_nxt));
    byp_nxt     = push_e;
    use_byp_nxt = step.neg && (cpop == CNT_W'(2));
    tail_nxt    = step.neg ? inc(tail_e) : tail_e;
    count_nxt   = cpop + CNT_W'(step.neg);
    seen_nxt    = (seen_e < window) ? seen_e + CNT_W'(1) : seen_e;
    pos_nxt     = pos_e + POS_W'(1);

    result.emit  = (seen_nxt >= window);
    result.value = (count_nxt != '0) ? f0_nxt.value : '0;
  end

  swfn_ram #(
    .WIDTH ($bits(swfn_entry_t)),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (step.go && step.neg),
    .waddr (tail_e),
    .wdata (push_e),
    .re    (step.go),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      seen_r    <= '0;
      pos_r     <= '0;
      use_byp_r <= 1'b0;
    end else if (step.go) begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      seen_r    <= seen_nxt;
      pos_r     <= pos_nxt;
      use_byp_r <= use_byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go) begin
      f0_r  <= f0_nxt;
      f1_r  <= f1_nxt;
      byp_r <= byp_nxt;
    end
  end

endmodule

`default_nettype wire
